### rtl/blti_pkg.sv
// shared constants and types of the bilinear log table interpolator
`timescale 1ns / 1ps
package blti_pkg;

    localparam int TEMP_POINTS_DEF  = 91;
    localparam int METAL_POINTS_DEF = 8;
    localparam int NUM_REGS         = 8;
    localparam int CFG_INDEX_W      = 4;

    // accumulator of the metallicity blend and the divider steps
    localparam int ACC_W     = 56;
    localparam int DIV_STEPS = 15;

    localparam logic signed [15:0] TEMP_FLOOR = 16'sd8192;
    localparam logic signed [15:0] RATE_MAX   = 16'sh7fff;
    localparam logic signed [15:0] RATE_MIN   = 16'sh8000;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [15:0] METAL_RESET [NUM_REGS] = '{
        -16'sd27439, -16'sd19247, -16'sd15151, -16'sd13103,
        -16'sd11055, -16'sd9007,  -16'sd6959,  -16'sd4911
    };

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/blti_div.sv
// floor division of the blended rate by the breakpoint gap, with saturation
`timescale 1ns / 1ps
module blti_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [blti_pkg::ACC_W-1:0] numer,
    input  logic        [15:0]               denom,
    output blti_pkg::div_stat_t              stat,
    output logic signed [15:0]               quot
);

    typedef enum logic {
        DV_IDLE,
        DV_RUN
    } dv_state_t;

    localparam int MAG_W = blti_pkg::ACC_W - 11;

    dv_state_t   state_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [14:0] dvd_reg;
    logic [15:0] denom_reg;
    logic        neg_reg;
    logic        sat_reg;
    logic        done_reg;

    logic signed [MAG_W-1:0] scaled;
    logic [MAG_W-1:0]        mag;
    logic                    ovf;
    logic [16:0]             trial;
    logic                    ge;

    // floor(n/2048) first, then a negative value goes through its complement
    assign scaled = numer[blti_pkg::ACC_W-1:11];
    assign mag    = scaled[MAG_W-1] ? ~scaled : scaled;
    assign ovf    = mag[MAG_W-1:15] >= {{(MAG_W - 31){1'b0}}, denom};

    assign trial = {rem_reg, dvd_reg[14]};
    assign ge    = trial >= {1'b0, denom_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            dvd_reg   <= '0;
            denom_reg <= '0;
            neg_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg   <= scaled[MAG_W-1];
                        denom_reg <= denom;
                        sat_reg   <= ovf;
                        rem_reg   <= mag[30:15];
                        dvd_reg   <= mag[14:0];
                        cnt_reg   <= 4'(blti_pkg::DIV_STEPS - 1);
                        if (ovf)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= DV_RUN;
                        end
                    end
                end
                DV_RUN:
                begin
                    rem_reg <= ge ? 16'(trial - {1'b0, denom_reg}) : trial[15:0];
                    dvd_reg <= {dvd_reg[13:0], ge};
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0)
                    begin
                        state_reg <= DV_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg == DV_RUN);
    assign stat.done = done_reg;

    always_comb
    begin
        if (sat_reg)
        begin
            quot = neg_reg ? blti_pkg::RATE_MIN : blti_pkg::RATE_MAX;
        end
        else if (neg_reg)
        begin
            quot = ~{1'b0, dvd_reg};
        end
        else
        begin
            quot = {1'b0, dvd_reg};
        end
    end

endmodule

### rtl/bilinear_log_table_interpolator.sv
// top level: rate table memory, breakpoint scan, blend sequencer and output register
// a table load leaves the sequencer idle and the next item is accepted in the following cycle
// a query goes through the breakpoint scan, four table reads with a shared 21x18 multiplier
// and a one-bit-per-cycle divider, whose bit steps are skipped when the quotient saturates
// reset restores the breakpoint registers; table contents are undefined until loaded
`timescale 1ns / 1ps
module bilinear_log_table_interpolator
#(
    parameter int TEMP_POINTS  = blti_pkg::TEMP_POINTS_DEF,
    parameter int METAL_POINTS = blti_pkg::METAL_POINTS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [blti_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [2:0]                         load_row,
    input  logic [6:0]                         load_col,
    input  logic signed [15:0]                 load_value,
    input  logic signed [15:0]                 log_temp,
    input  logic signed [15:0]                 log_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [15:0]                 log_rate
);

    localparam int TABLE_DEPTH = METAL_POINTS * TEMP_POINTS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ACC_W       = blti_pkg::ACC_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_A0,
        S_A1,
        S_A2,
        S_A3,
        S_B0,
        S_B1,
        S_B2,
        S_B3,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_DSTART,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0] i_reg;
    logic out_valid_reg;
    logic signed [15:0] log_rate_reg;

    logic signed [15:0] metal_point_reg [blti_pkg::NUM_REGS];

    logic signed [15:0] rate_mem [TABLE_DEPTH];
    logic signed [15:0] rd_data_reg;

    logic [7:0]  col_reg;
    logic [18:0] u_reg;
    logic signed [15:0] z_reg;
    logic [15:0] g_reg;
    logic signed [16:0] wa_reg;
    logic signed [16:0] wb_reg;
    logic signed [15:0] r0_reg;
    logic signed [16:0] diff_reg;
    logic signed [38:0] prod_reg;
    logic signed [36:0] ra_reg;
    logic signed [36:0] rb_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic in_accept;
    logic load_ok;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] addr_a0;
    logic [ADDR_W-1:0] addr_b0;

    logic signed [15:0] t_clamp;
    logic [14:0] d_off;
    logic [18:0] d20;
    logic [7:0]  col_raw;
    logic [7:0]  col_cap;
    logic [7:0]  col_q;
    logic [18:0] u_q;
    logic signed [15:0] z_lo;
    logic signed [15:0] z_clamp;

    logic [2:0] i_hi;
    logic signed [15:0] m_lo;
    logic signed [15:0] m_hi;
    logic scan_adv;
    logic signed [16:0] gap;
    logic gap_pos;

    logic signed [20:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [38:0] mul_p;
    logic signed [36:0] row_sum;

    blti_pkg::div_stat_t div_stat;
    logic signed [15:0] div_quot;
    logic div_start;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign log_rate  = log_rate_reg;

    // breakpoint registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < blti_pkg::NUM_REGS; k++)
            begin
                metal_point_reg[k] <= blti_pkg::METAL_RESET[k];
            end
        end
        else if (cfg_valid && cfg_ready &&
                 (cfg_index < blti_pkg::CFG_INDEX_W'(blti_pkg::NUM_REGS)))
        begin
            metal_point_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // query setup: temperature column and offset, metallicity clamp
    assign t_clamp = (log_temp < blti_pkg::TEMP_FLOOR) ? blti_pkg::TEMP_FLOOR : log_temp;
    assign d_off   = 15'(t_clamp - blti_pkg::TEMP_FLOOR);
    assign d20     = {d_off, 4'b0000} + {2'b00, d_off, 2'b00};
    assign col_raw = d20[18:11];
    assign col_cap = 8'(TEMP_POINTS - 2);
    assign col_q   = (col_raw > col_cap) ? col_cap : col_raw;
    assign u_q     = d20 - {col_q, 11'd0};

    assign z_lo    = (log_z < metal_point_reg[0]) ? metal_point_reg[0] : log_z;
    assign z_clamp = (z_lo > metal_point_reg[METAL_POINTS - 1]) ?
                     metal_point_reg[METAL_POINTS - 1] : z_lo;

    // row scan
    assign i_hi     = i_reg + 3'd1;
    assign m_lo     = metal_point_reg[i_reg];
    assign m_hi     = metal_point_reg[i_hi];
    assign scan_adv = (i_reg < 3'(METAL_POINTS - 2)) && (z_reg > m_hi);
    assign gap      = {m_hi[15], m_hi} - {m_lo[15], m_lo};
    assign gap_pos  = !gap[16] && (gap != 17'sd0);

    // table addressing
    assign load_ok = ({1'b0, load_row} < 4'(METAL_POINTS)) &&
                     ({2'b00, load_col} < 9'(TEMP_POINTS));
    assign waddr   = ADDR_W'(32'(load_row) * 32'(TEMP_POINTS)) + ADDR_W'(load_col);
    assign addr_a0 = ADDR_W'(32'(i_reg) * 32'(TEMP_POINTS)) + ADDR_W'(col_reg);
    assign addr_b0 = addr_a0 + ADDR_W'(TEMP_POINTS);

    always_comb
    begin
        case (state_reg)
            S_A0:    raddr = addr_a0 + ADDR_W'(1);
            S_A3:    raddr = addr_b0;
            S_B0:    raddr = addr_b0 + ADDR_W'(1);
            default: raddr = addr_a0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (operation == blti_pkg::OP_LOAD) && load_ok)
        begin
            rate_mem[waddr] <= load_value;
        end
        rd_data_reg <= rate_mem[raddr];
    end

    // shared multiplier: temperature slope, then the row values split in two parts times the row weights
    always_comb
    begin
        case (state_reg)
            S_M0:
            begin
                mul_a = {1'b0, ra_reg[19:0]};
                mul_b = {wa_reg[16], wa_reg};
            end
            S_M1:
            begin
                mul_a = {{4{ra_reg[36]}}, ra_reg[36:20]};
                mul_b = {wa_reg[16], wa_reg};
            end
            S_M2:
            begin
                mul_a = {1'b0, rb_reg[19:0]};
                mul_b = {wb_reg[16], wb_reg};
            end
            S_M3:
            begin
                mul_a = {{4{rb_reg[36]}}, rb_reg[36:20]};
                mul_b = {wb_reg[16], wb_reg};
            end
            default:
            begin
                mul_a = {2'b00, u_reg};
                mul_b = {diff_reg[16], diff_reg};
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign row_sum = {{10{r0_reg[15]}}, r0_reg, 11'd0} + prod_reg[36:0];

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    col_reg <= col_q;
                    u_reg   <= u_q;
                    z_reg   <= z_clamp;
                end
            end
            S_SCAN:
            begin
                if (!scan_adv)
                begin
                    if (gap_pos)
                    begin
                        g_reg  <= gap[15:0];
                        wa_reg <= {m_hi[15], m_hi} - {z_reg[15], z_reg};
                        wb_reg <= {z_reg[15], z_reg} - {m_lo[15], m_lo};
                    end
                    else
                    begin
                        // breakpoints not ascending: row i alone
                        g_reg  <= 16'd1;
                        wa_reg <= 17'sd1;
                        wb_reg <= 17'sd0;
                    end
                end
            end
            S_A0, S_B0:
            begin
                r0_reg <= rd_data_reg;
            end
            S_A1, S_B1:
            begin
                diff_reg <= {rd_data_reg[15], rd_data_reg} - {r0_reg[15], r0_reg};
            end
            S_A2, S_B2, S_M0:
            begin
                prod_reg <= mul_p;
            end
            S_A3:
            begin
                ra_reg <= row_sum;
            end
            S_B3:
            begin
                rb_reg  <= row_sum;
                // rounding bias of half a step
                acc_reg <= {{(ACC_W - 26){1'b0}}, g_reg, 10'd0};
            end
            S_M1, S_M3:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + {{(ACC_W - 39){prod_reg[38]}}, prod_reg};
            end
            S_M2, S_M4:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + {prod_reg[ACC_W-21:0], 20'd0};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign div_start = (state_reg == S_DSTART);

    blti_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (acc_reg),
        .denom (g_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
            log_rate_reg  <= '0;
        end
        else
        begin
            // the result state refills the output register itself
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && (operation == blti_pkg::OP_QUERY))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_adv)
                    begin
                        i_reg <= i_hi;
                    end
                    else
                    begin
                        state_reg <= S_A0;
                    end
                end
                S_A0:     state_reg <= S_A1;
                S_A1:     state_reg <= S_A2;
                S_A2:     state_reg <= S_A3;
                S_A3:     state_reg <= S_B0;
                S_B0:     state_reg <= S_B1;
                S_B1:     state_reg <= S_B2;
                S_B2:     state_reg <= S_B3;
                S_B3:     state_reg <= S_M0;
                S_M0:     state_reg <= S_M1;
                S_M1:     state_reg <= S_M2;
                S_M2:     state_reg <= S_M3;
                S_M3:     state_reg <= S_M4;
                S_M4:     state_reg <= S_DSTART;
                S_DSTART: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        log_rate_reg  <= div_quot;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_out_from_sequencer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result shown without a finished query");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (i_reg <= 3'(METAL_POINTS - 2)))
        else $error("row index past the last bracketing pair");

    a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (operation == blti_pkg::OP_LOAD)) |=> (state_reg == S_IDLE))
        else $error("table load left the sequencer busy");

    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("divider idle while the sequencer waits on it");

endmodule
